FILE: hdl/csma_pkg.sv
`default_nettype none

package csma_pkg;

   // timing constants, in symbols
   localparam int UNIT_BACKOFF_SYMBOLS = 20;
   localparam int TURNAROUND_SYMBOLS   = 12;

   // field widths
   localparam int PERIOD_BITS = 8;
   localparam int CAP_BITS    = 24;
   localparam int COST_BITS   = 14;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 4;

   // largest exponent used in the backoff mask
   localparam logic [3:0] MASK_EXP_MAX = 4'd8;
   localparam logic [2:0] BUSY_COUNT_MAX = 3'd7;
   localparam logic [1:0] WINDOW_INIT = 2'd2;
   localparam logic [3:0] BLE_EXP_MAX = 4'd2;

   // divide by the unit backoff through a reciprocal multiply; the quotient is
   // needed only when the cap fits under 255 backoff periods
   localparam int DIV_BITS  = $clog2(255 * UNIT_BACKOFF_SYMBOLS + 1);
   localparam int DIV_LOG   = $clog2(UNIT_BACKOFF_SYMBOLS);
   localparam int DIV_SHIFT = DIV_BITS + DIV_LOG;
   localparam int DIV_RECIP = ((2 ** DIV_SHIFT) + UNIT_BACKOFF_SYMBOLS - 1)
                              / UNIT_BACKOFF_SYMBOLS;

   localparam logic [DIV_BITS-1:0] UNIT_W = DIV_BITS'(UNIT_BACKOFF_SYMBOLS);
   localparam logic [COST_BITS-1:0] TURN_COST = COST_BITS'(2 * TURNAROUND_SYMBOLS);

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLOTTED_MODE     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BATTERY_LIFE_EXT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_EXPONENT     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_EXPONENT     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_BACKOFFS     = 3'd4;

   typedef enum logic [1:0] {
      MODE_START  = 2'd0,
      MODE_TICK   = 2'd1,
      MODE_CCA    = 2'd2,
      MODE_CANCEL = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_CCA   = 3'd1,
      ACT_IDLE  = 3'd2,
      ACT_FAIL  = 3'd3,
      ACT_DEFER = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_BACKOFF = 2'd1,
      PH_CCA     = 2'd2
   } phase_type;

   typedef struct packed {
      logic       slotted_mode;
      logic       battery_life_ext;
      logic [3:0] min_exponent;
      logic [3:0] max_exponent;
      logic [2:0] max_backoffs;
   } cfg_type;

   typedef struct packed {
      mode_type              mode;
      logic [7:0]            random_value;
      logic                  channel_busy;
      logic [CAP_BITS-1:0]   cap_symbols_left;
      logic [11:0]           frame_symbols;
      logic                  ack_required;
      logic [11:0]           ack_wait_symbols;
      logic [7:0]            ifs_symbols;
   } req_type;

   typedef struct packed {
      logic [2:0]             busy_count;
      logic [3:0]             exponent;
      logic [1:0]             window_count;
      logic [PERIOD_BITS-1:0] periods_left;
      phase_type              phase;
      logic [COST_BITS-1:0]   frame_cost_base;
   } state_type;

   typedef struct packed {
      action_type             action;
      logic [PERIOD_BITS-1:0] backoff_periods_left;
      logic [2:0]             backoff_count;
      logic [3:0]             backoff_exponent;
      logic [COST_BITS-1:0]   transaction_symbols;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/csma_div.sv
`default_nettype none

// Backoff periods that fit in the CAP symbols left: cap / unit backoff.
// Exact for every cap below 2^DIV_BITS; larger caps are never used.
module csma_div (
   input  wire logic [csma_pkg::CAP_BITS-1:0] cap,
   output logic [csma_pkg::DIV_BITS-1:0]      quotient
);

   localparam int PROD_BITS = csma_pkg::DIV_BITS + csma_pkg::DIV_SHIFT + 1;

   localparam logic [csma_pkg::DIV_SHIFT:0] RECIP_W =
      (csma_pkg::DIV_SHIFT + 1)'(csma_pkg::DIV_RECIP);

   logic [PROD_BITS-1:0] product;

   // one multiply by the rounded-up reciprocal, then drop the fraction
   assign product  = PROD_BITS'(cap[csma_pkg::DIV_BITS-1:0]) * PROD_BITS'(RECIP_W);
   assign quotient = product[csma_pkg::DIV_SHIFT +: csma_pkg::DIV_BITS];

endmodule

`default_nettype wire

FILE: hdl/csma_step.sv
`default_nettype none

// Next state and result for one word, from the current state and config.
module csma_step (
   input  wire csma_pkg::cfg_type   cfg,
   input  wire csma_pkg::req_type   req,
   input  wire csma_pkg::state_type cur,
   output csma_pkg::state_type      nxt,
   output csma_pkg::rsp_type        rsp
);

   logic [csma_pkg::DIV_BITS-1:0]    used_periods;
   logic [csma_pkg::DIV_BITS-1:0]    backoff_symbols;
   logic [csma_pkg::COST_BITS-1:0]   cost;
   logic [csma_pkg::PERIOD_BITS-1:0] drawn;
   logic [csma_pkg::PERIOD_BITS-1:0] mask;
   logic [3:0]                       mask_exp;
   logic [3:0]                       busy_next;
   logic [4:0]                       exp_inc;
   logic                             do_draw;
   logic                             do_proceed;
   csma_pkg::action_type             act;

   csma_div u_div (
      .cap      (req.cap_symbols_left),
      .quotient (used_periods)
   );

   always_comb begin
      nxt        = cur;
      act        = csma_pkg::ACT_NONE;
      do_draw    = 1'b0;
      do_proceed = 1'b0;
      busy_next  = {1'b0, cur.busy_count} + 4'd1;
      exp_inc    = {1'b0, cur.exponent} + 5'd1;

      // a stray phase code counts as idle
      if (cur.phase != csma_pkg::PH_BACKOFF && cur.phase != csma_pkg::PH_CCA) begin
         nxt.phase = csma_pkg::PH_IDLE;
      end

      // per-mode update
      unique case (req.mode)
         csma_pkg::MODE_START: begin
            nxt.busy_count = '0;
            if (cfg.slotted_mode) begin
               nxt.window_count = csma_pkg::WINDOW_INIT;
               nxt.exponent = (cfg.battery_life_ext && cfg.min_exponent > csma_pkg::BLE_EXP_MAX)
                            ? csma_pkg::BLE_EXP_MAX : cfg.min_exponent;
            end else begin
               nxt.exponent = cfg.min_exponent;
            end
            nxt.frame_cost_base = csma_pkg::COST_BITS'(req.frame_symbols)
                                + csma_pkg::COST_BITS'(req.ifs_symbols)
                                + (req.ack_required ? csma_pkg::COST_BITS'(req.ack_wait_symbols)
                                                    : csma_pkg::TURN_COST);
            do_draw = 1'b1;
         end
         csma_pkg::MODE_TICK: begin
            if (cur.phase == csma_pkg::PH_BACKOFF) begin
               if (cur.periods_left != '0) begin
                  nxt.periods_left = cur.periods_left - csma_pkg::PERIOD_BITS'(1);
               end
               if (cur.periods_left <= csma_pkg::PERIOD_BITS'(1)) begin
                  if (cfg.slotted_mode) begin
                     do_proceed = 1'b1;
                  end else begin
                     nxt.phase = csma_pkg::PH_CCA;
                     act       = csma_pkg::ACT_CCA;
                  end
               end
            end
         end
         csma_pkg::MODE_CCA: begin
            if (cur.phase == csma_pkg::PH_CCA) begin
               nxt.phase = csma_pkg::PH_IDLE;
               if (!req.channel_busy) begin
                  if (cfg.slotted_mode && cur.window_count > 2'd1) begin
                     nxt.window_count = cur.window_count - 2'd1;
                     nxt.phase        = csma_pkg::PH_CCA;
                     act              = csma_pkg::ACT_CCA;
                  end else begin
                     if (cfg.slotted_mode) begin
                        nxt.window_count = '0;
                     end
                     act = csma_pkg::ACT_IDLE;
                  end
               end else begin
                  if (cfg.slotted_mode) begin
                     nxt.window_count = csma_pkg::WINDOW_INIT;
                  end
                  nxt.exponent = (exp_inc > {1'b0, cfg.max_exponent})
                               ? cfg.max_exponent : exp_inc[3:0];
                  nxt.busy_count = (busy_next > {1'b0, csma_pkg::BUSY_COUNT_MAX})
                                 ? csma_pkg::BUSY_COUNT_MAX : busy_next[2:0];
                  if (busy_next > {1'b0, cfg.max_backoffs}) begin
                     act = csma_pkg::ACT_FAIL;
                  end else begin
                     do_draw = 1'b1;
                  end
               end
            end
         end
         csma_pkg::MODE_CANCEL: begin
            nxt.phase        = csma_pkg::PH_IDLE;
            nxt.periods_left = '0;
         end
      endcase

      // backoff draw; slotted mode reuses periods left over from a deferral
      mask_exp = (nxt.exponent > csma_pkg::MASK_EXP_MAX) ? csma_pkg::MASK_EXP_MAX
                                                         : nxt.exponent;
      mask = (mask_exp >= csma_pkg::MASK_EXP_MAX) ? '1
           : csma_pkg::PERIOD_BITS'((9'd1 << mask_exp) - 9'd1);
      drawn = (nxt.periods_left == '0 || !cfg.slotted_mode)
            ? (req.random_value & mask) : nxt.periods_left;
      backoff_symbols = csma_pkg::DIV_BITS'(drawn) * csma_pkg::UNIT_W;

      if (do_draw) begin
         nxt.periods_left = drawn;
         if (!cfg.slotted_mode) begin
            if (drawn == '0) begin
               nxt.phase = csma_pkg::PH_CCA;
               act       = csma_pkg::ACT_CCA;
            end else begin
               nxt.phase = csma_pkg::PH_BACKOFF;
            end
         end else if (csma_pkg::CAP_BITS'(backoff_symbols) >= req.cap_symbols_left) begin
            // backoff runs past the CAP: spend what fits, finish next CAP
            nxt.periods_left = drawn - used_periods[csma_pkg::PERIOD_BITS-1:0];
            nxt.phase        = csma_pkg::PH_IDLE;
            act              = csma_pkg::ACT_DEFER;
         end else if (drawn == '0) begin
            do_proceed = 1'b1;
         end else begin
            nxt.phase = csma_pkg::PH_BACKOFF;
         end
      end

      // slotted check that the whole transaction fits in the CAP
      cost = csma_pkg::COST_BITS'({nxt.window_count, 3'b000}) + nxt.frame_cost_base;
      if (do_proceed) begin
         nxt.periods_left = '0;
         if (csma_pkg::CAP_BITS'(cost) > req.cap_symbols_left) begin
            nxt.phase = csma_pkg::PH_IDLE;
            act       = csma_pkg::ACT_DEFER;
         end else begin
            nxt.phase = csma_pkg::PH_CCA;
            act       = csma_pkg::ACT_CCA;
         end
      end

      rsp.action               = act;
      rsp.backoff_periods_left = nxt.periods_left;
      rsp.backoff_count        = nxt.busy_count;
      rsp.backoff_exponent     = nxt.exponent;
      rsp.transaction_symbols  = do_proceed ? cost : '0;
   end

endmodule

`default_nettype wire

FILE: hdl/csma_ca_backoff_controller_top.sv
`default_nettype none

// CSMA-CA backoff engine.
// An accepted request word passes the input register, then the state update
// into the response register. Throughput: one word per cycle unless rsp_stall
// holds the pipeline; the state update is combinational.
// Reset: synchronous, active high; clears the pipeline valids, sets the
// engine state to idle (exponent 3, window 2) and the registers to defaults.
module csma_ca_backoff_controller_top (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [7:0]  req_random_value,
   input  wire logic        req_channel_busy,
   input  wire logic [23:0] req_cap_symbols_left,
   input  wire logic [11:0] req_frame_symbols,
   input  wire logic        req_ack_required,
   input  wire logic [11:0] req_ack_wait_symbols,
   input  wire logic [7:0]  req_ifs_symbols,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_action,
   output logic [7:0]       rsp_backoff_periods_left,
   output logic [2:0]       rsp_backoff_count,
   output logic [3:0]       rsp_backoff_exponent,
   output logic [13:0]      rsp_transaction_symbols,

   input  wire logic        csr_write,
   input  wire logic [csma_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [csma_pkg::CSR_DATA_BITS-1:0] csr_data
);

   csma_pkg::cfg_type   cfg_ff;
   csma_pkg::req_type   req_ff;
   csma_pkg::req_type   req_in;
   logic                req_valid_ff;
   csma_pkg::state_type state_ff;
   csma_pkg::state_type state_in;
   csma_pkg::rsp_type   rsp_ff;
   csma_pkg::rsp_type   rsp_in;
   logic                rsp_valid_ff;
   logic                advance;
   logic                req_take;

   // pipeline control: the input word moves on when the response slot frees
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign req_in.mode             = csma_pkg::mode_type'(req_mode);
   assign req_in.random_value     = req_random_value;
   assign req_in.channel_busy     = req_channel_busy;
   assign req_in.cap_symbols_left = req_cap_symbols_left;
   assign req_in.frame_symbols    = req_frame_symbols;
   assign req_in.ack_required     = req_ack_required;
   assign req_in.ack_wait_symbols = req_ack_wait_symbols;
   assign req_in.ifs_symbols      = req_ifs_symbols;

   csma_step u_step (
      .cfg (cfg_ff),
      .req (req_ff),
      .cur (state_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slotted_mode     <= 1'b0;
         cfg_ff.battery_life_ext <= 1'b0;
         cfg_ff.min_exponent     <= 4'd3;
         cfg_ff.max_exponent     <= 4'd5;
         cfg_ff.max_backoffs     <= 3'd4;
      end else if (csr_write) begin
         unique case (csr_index)
            csma_pkg::CSR_SLOTTED_MODE:     cfg_ff.slotted_mode     <= csr_data[0];
            csma_pkg::CSR_BATTERY_LIFE_EXT: cfg_ff.battery_life_ext <= csr_data[0];
            csma_pkg::CSR_MIN_EXPONENT:     cfg_ff.min_exponent     <= csr_data;
            csma_pkg::CSR_MAX_EXPONENT:     cfg_ff.max_exponent     <= csr_data;
            csma_pkg::CSR_MAX_BACKOFFS:     cfg_ff.max_backoffs     <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_take) begin
         req_valid_ff <= 1'b1;
      end else if (advance) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
   end

   // engine state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.busy_count      <= '0;
         state_ff.exponent        <= 4'd3;
         state_ff.window_count    <= csma_pkg::WINDOW_INIT;
         state_ff.periods_left    <= '0;
         state_ff.phase           <= csma_pkg::PH_IDLE;
         state_ff.frame_cost_base <= '0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_action               = rsp_ff.action;
   assign rsp_backoff_periods_left = rsp_ff.backoff_periods_left;
   assign rsp_backoff_count        = rsp_ff.backoff_count;
   assign rsp_backoff_exponent     = rsp_ff.backoff_exponent;
   assign rsp_transaction_symbols  = rsp_ff.transaction_symbols;

   // a cancel leaves the engine idle with no periods pending
   a_cancel_clears: assert property (@(posedge clock) disable iff (reset)
      advance && req_ff.mode == csma_pkg::MODE_CANCEL |=>
         state_ff.phase == csma_pkg::PH_IDLE && state_ff.periods_left == '0)
      else $error("cancel did not clear the engine");

   // a deferral always parks the engine
   a_defer_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.action == csma_pkg::ACT_DEFER |->
         state_ff.phase == csma_pkg::PH_IDLE)
      else $error("deferral left the engine active");

   // a transaction cost is reported only by the proceed check
   a_cost_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.transaction_symbols != '0 |->
         rsp_ff.action == csma_pkg::ACT_CCA || rsp_ff.action == csma_pkg::ACT_DEFER)
      else $error("transaction cost without a proceed check");

   // a CCA request leaves a CCA pending
   a_cca_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.action == csma_pkg::ACT_CCA |->
         state_ff.phase == csma_pkg::PH_CCA && state_ff.periods_left == '0)
      else $error("CCA requested without a pending CCA");

endmodule

`default_nettype wire

FILE: tb/sv/tb_csma_ca_backoff_controller_top.sv
`timescale 1ns / 1ps

module tb_csma_ca_backoff_controller_top;
   import csma_pkg::*;

   localparam int HOLD_CYCLES = 200;
   localparam int PHASE_WORDS = 150;
   localparam int DRAIN_CYCLES = 4;

   // clock, reset and block inputs, all known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   req_type req_word = '0;
   logic rsp_stall = 1'b0;
   logic csr_write = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   logic req_stall;
   logic rsp_valid;
   logic [2:0] rsp_action;
   logic [7:0] rsp_backoff_periods_left;
   logic [2:0] rsp_backoff_count;
   logic [3:0] rsp_backoff_exponent;
   logic [13:0] rsp_transaction_symbols;

   // access engine shadow state and register copy
   cfg_type model_cfg;
   logic [2:0] nb_count;
   logic [3:0] be_value;
   logic [1:0] cw_left;
   logic [7:0] bo_periods;
   phase_type csma_phase;
   logic [13:0] cost_base;
   logic [13:0] txn_cost;

   rsp_type pending_rsp [$];
   int err_count = 0;
   int words_sent = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   bit hold_req = 1'b0;

   csma_ca_backoff_controller_top DUT (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_mode                 (req_word.mode),
      .req_random_value         (req_word.random_value),
      .req_channel_busy         (req_word.channel_busy),
      .req_cap_symbols_left     (req_word.cap_symbols_left),
      .req_frame_symbols        (req_word.frame_symbols),
      .req_ack_required         (req_word.ack_required),
      .req_ack_wait_symbols     (req_word.ack_wait_symbols),
      .req_ifs_symbols          (req_word.ifs_symbols),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_action               (rsp_action),
      .rsp_backoff_periods_left (rsp_backoff_periods_left),
      .rsp_backoff_count        (rsp_backoff_count),
      .rsp_backoff_exponent     (rsp_backoff_exponent),
      .rsp_transaction_symbols  (rsp_transaction_symbols),
      .csr_write                (csr_write),
      .csr_index                (csr_index),
      .csr_data                 (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // hard stop in case something hangs
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic cfg_type make_cfg(logic s, logic b, logic [3:0] mn, logic [3:0] mx,
                                        logic [2:0] bo);
      cfg_type c;
      c.slotted_mode = s;
      c.battery_life_ext = b;
      c.min_exponent = mn;
      c.max_exponent = mx;
      c.max_backoffs = bo;
      return c;
   endfunction

   task automatic reset_model();
      model_cfg = make_cfg(1'b0, 1'b0, 4'd3, 4'd5, 3'd4);
      nb_count = '0;
      be_value = 4'd3;
      cw_left = WINDOW_INIT;
      bo_periods = '0;
      csma_phase = PH_IDLE;
      cost_base = '0;
      txn_cost = '0;
   endtask

   // slotted check that the whole transaction fits in the CAP
   function automatic action_type fit_check(logic [23:0] cap);
      logic [13:0] cost;
      cost = 14'(8 * cw_left + cost_base);
      bo_periods = '0;
      txn_cost = cost;
      if (32'(cost) > 32'(cap)) begin
         csma_phase = PH_IDLE;
         return ACT_DEFER;
      end
      csma_phase = PH_CCA;
      return ACT_CCA;
   endfunction

   // draw a backoff (or reuse a deferred one) and decide the next step
   function automatic action_type pick_backoff(logic [7:0] rnd, logic [23:0] cap);
      logic [3:0] be;
      logic [8:0] mask9;
      int unsigned used;
      be = (be_value > MASK_EXP_MAX) ? MASK_EXP_MAX : be_value;
      mask9 = (9'd1 << be) - 9'd1;
      if (bo_periods == 0 || !model_cfg.slotted_mode)
         bo_periods = rnd & mask9[7:0];
      if (!model_cfg.slotted_mode) begin
         if (bo_periods == 0) begin
            csma_phase = PH_CCA;
            return ACT_CCA;
         end
         csma_phase = PH_BACKOFF;
         return ACT_NONE;
      end
      if (32'(bo_periods) * UNIT_BACKOFF_SYMBOLS >= 32'(cap)) begin
         used = 32'(cap) / UNIT_BACKOFF_SYMBOLS;
         bo_periods = 8'(32'(bo_periods) - used);
         csma_phase = PH_IDLE;
         return ACT_DEFER;
      end
      if (bo_periods == 0)
         return fit_check(cap);
      csma_phase = PH_BACKOFF;
      return ACT_NONE;
   endfunction

   // advance the shadow engine by one accepted request word
   function automatic rsp_type predict_response(req_type w);
      rsp_type r;
      action_type act;
      int unsigned nb;
      act = ACT_NONE;
      txn_cost = '0;
      case (w.mode)
         MODE_START: begin
            nb_count = '0;
            if (model_cfg.slotted_mode) begin
               cw_left = WINDOW_INIT;
               be_value = (model_cfg.battery_life_ext && model_cfg.min_exponent > BLE_EXP_MAX)
                          ? BLE_EXP_MAX : model_cfg.min_exponent;
            end else begin
               be_value = model_cfg.min_exponent;
            end
            cost_base = 14'(32'(w.frame_symbols) + 32'(w.ifs_symbols) +
                            (w.ack_required ? 32'(w.ack_wait_symbols)
                                            : 32'(2 * TURNAROUND_SYMBOLS)));
            act = pick_backoff(w.random_value, w.cap_symbols_left);
         end
         MODE_TICK: begin
            if (csma_phase == PH_BACKOFF) begin
               if (bo_periods > 0)
                  bo_periods = bo_periods - 8'd1;
               if (bo_periods == 0) begin
                  if (model_cfg.slotted_mode) begin
                     act = fit_check(w.cap_symbols_left);
                  end else begin
                     csma_phase = PH_CCA;
                     act = ACT_CCA;
                  end
               end
            end
         end
         MODE_CCA: begin
            if (csma_phase == PH_CCA) begin
               csma_phase = PH_IDLE;
               if (!w.channel_busy) begin
                  if (model_cfg.slotted_mode) begin
                     if (cw_left <= 2'd1) begin
                        cw_left = '0;
                        act = ACT_IDLE;
                     end else begin
                        cw_left = cw_left - 2'd1;
                        csma_phase = PH_CCA;
                        act = ACT_CCA;
                     end
                  end else begin
                     act = ACT_IDLE;
                  end
               end else begin
                  // busy channel: widen the exponent and back off again
                  nb = 32'(nb_count) + 1;
                  if (model_cfg.slotted_mode)
                     cw_left = WINDOW_INIT;
                  be_value = (32'(be_value) + 1 > 32'(model_cfg.max_exponent))
                             ? model_cfg.max_exponent : be_value + 4'd1;
                  nb_count = (nb > 7) ? BUSY_COUNT_MAX : 3'(nb);
                  if (nb > 32'(model_cfg.max_backoffs))
                     act = ACT_FAIL;
                  else
                     act = pick_backoff(w.random_value, w.cap_symbols_left);
               end
            end
         end
         default: begin
            csma_phase = PH_IDLE;
            bo_periods = '0;
         end
      endcase
      r.action = act;
      r.backoff_periods_left = bo_periods;
      r.backoff_count = nb_count;
      r.backoff_exponent = be_value;
      r.transaction_symbols = txn_cost;
      return r;
   endfunction

   task automatic flag_error(string msg);
      err_count++;
      if (err_count <= 100)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   // compare one accepted response word with the oldest prediction
   task automatic check_word();
      rsp_type want;
      if (pending_rsp.size() == 0) begin
         flag_error("response word with no prediction pending");
         return;
      end
      want = pending_rsp.pop_front();
      if (rsp_action != want.action)
         flag_error($sformatf("action got %0d want %0d", rsp_action, want.action));
      if (rsp_backoff_periods_left != want.backoff_periods_left)
         flag_error($sformatf("periods left got %0d want %0d",
                              rsp_backoff_periods_left, want.backoff_periods_left));
      if (rsp_backoff_count != want.backoff_count)
         flag_error($sformatf("backoff count got %0d want %0d",
                              rsp_backoff_count, want.backoff_count));
      if (rsp_backoff_exponent != want.backoff_exponent)
         flag_error($sformatf("exponent got %0d want %0d",
                              rsp_backoff_exponent, want.backoff_exponent));
      if (rsp_transaction_symbols != want.transaction_symbols)
         flag_error($sformatf("transaction symbols got %0d want %0d",
                              rsp_transaction_symbols, want.transaction_symbols));
   endtask

   // response side: check, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         check_word();
      if (hold_req) begin
         hold_req = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // offer one request word, with random idle cycles ahead of it
   task automatic send_word(req_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      pending_rsp.push_back(predict_response(w));
      words_sent++;
   endtask

   function automatic logic [23:0] pick_cap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 24'($urandom_range(9000, 24'hFFFFFF));
      else if (r < 88)
         return 24'($urandom_range(0, 6000));
      return 24'($urandom);
   endfunction

   function automatic req_type make_word(mode_type m);
      req_type w;
      w.mode = m;
      w.random_value = 8'($urandom_range(0, 255));
      w.channel_busy = 1'($urandom_range(0, 1));
      w.cap_symbols_left = pick_cap();
      w.frame_symbols = 12'($urandom_range(0, 4095));
      w.ack_required = 1'($urandom_range(0, 1));
      w.ack_wait_symbols = 12'($urandom_range(0, 4095));
      w.ifs_symbols = 8'($urandom_range(0, 255));
      return w;
   endfunction

   // directed word: chosen control fields, costs random or at their maximum
   task automatic send_item(mode_type m, logic [7:0] rnd, logic busy, logic [23:0] cap,
                            bit heavy);
      req_type w;
      w = make_word(m);
      w.random_value = rnd;
      w.channel_busy = busy;
      w.cap_symbols_left = cap;
      if (heavy) begin
         w.frame_symbols = 12'hFFF;
         w.ack_required = 1'b1;
         w.ack_wait_symbols = 12'hFFF;
         w.ifs_symbols = 8'hFF;
      end
      send_word(w);
   endtask

   // let every outstanding word come back, then settle
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(cfg_type c);
      logic [CSR_IDX_BITS-1:0] reg_idx [5];
      logic [CSR_DATA_BITS-1:0] reg_val [5];
      reg_idx[0] = CSR_SLOTTED_MODE;
      reg_idx[1] = CSR_BATTERY_LIFE_EXT;
      reg_idx[2] = CSR_MIN_EXPONENT;
      reg_idx[3] = CSR_MAX_EXPONENT;
      reg_idx[4] = CSR_MAX_BACKOFFS;
      reg_val[0] = 4'(c.slotted_mode);
      reg_val[1] = 4'(c.battery_life_ext);
      reg_val[2] = c.min_exponent;
      reg_val[3] = c.max_exponent;
      reg_val[4] = 4'(c.max_backoffs);
      for (int i = 0; i < 5; i++) begin
         csr_write <= 1'b1;
         csr_index <= reg_idx[i];
         csr_data <= reg_val[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      model_cfg = c;
   endtask

   // one channel access attempt driven to its end, with some noise mixed in
   task automatic run_attempt();
      req_type w;
      send_word(make_word(MODE_START));
      while (csma_phase != PH_IDLE) begin
         if ($urandom_range(0, 99) < 6) begin
            w = make_word(mode_type'($urandom_range(0, 3)));
         end else if (csma_phase == PH_BACKOFF) begin
            w = make_word(MODE_TICK);
         end else begin
            w = make_word(MODE_CCA);
            w.channel_busy = ($urandom_range(0, 99) < 35);
         end
         send_word(w);
      end
      if ($urandom_range(0, 99) < 10)
         send_word(make_word(mode_type'($urandom_range(0, 3))));
   endtask

   task automatic test_directed_unslotted();
      send_item(MODE_TICK, 8'd0, 1'b0, 24'd0, 1'b0);        // tick while idle
      send_item(MODE_CCA, 8'd0, 1'b1, 24'd0, 1'b0);         // confirm while idle
      send_item(MODE_START, 8'd0, 1'b0, 24'hFFFFFF, 1'b1);  // zero backoff
      send_item(MODE_CCA, 8'd1, 1'b1, 24'd0, 1'b0);         // busy, redraw
      send_item(MODE_TICK, 8'd0, 1'b0, 24'd0, 1'b0);
      send_item(MODE_CCA, 8'd0, 1'b0, 24'd0, 1'b0);         // idle channel
      send_item(MODE_START, 8'hFF, 1'b0, 24'd0, 1'b0);
      send_item(MODE_START, 8'd0, 1'b0, 24'd0, 1'b0);       // restart while busy
      send_item(MODE_CANCEL, 8'hFF, 1'b1, 24'hFFFFFF, 1'b0);
      drain_pipe();
   endtask

   task automatic test_directed_slotted();
      write_config(make_cfg(1'b1, 1'b1, 4'd3, 4'd8, 3'd0));
      send_item(MODE_START, 8'd0, 1'b0, 24'hFFFFFF, 1'b0);  // zero backoff, fits
      send_item(MODE_CCA, 8'd0, 1'b0, 24'd0, 1'b0);         // window down to one
      send_item(MODE_CCA, 8'd0, 1'b0, 24'd0, 1'b0);         // window exhausted
      send_item(MODE_START, 8'd3, 1'b0, 24'd20, 1'b0);      // backoff deferred
      send_item(MODE_START, 8'd0, 1'b0, 24'hFFFFFF, 1'b1);  // reuse leftover periods
      send_item(MODE_TICK, 8'd0, 1'b0, 24'hFFFFFF, 1'b0);
      send_item(MODE_TICK, 8'd0, 1'b0, 24'd8460, 1'b0);     // transaction misses by one
      send_item(MODE_START, 8'd0, 1'b0, 24'd8461, 1'b1);    // transaction fits exactly
      send_item(MODE_CCA, 8'd0, 1'b1, 24'd0, 1'b0);         // no busy CCA tolerated
      send_item(MODE_START, 8'd0, 1'b0, 24'd0, 1'b0);       // empty CAP
      send_item(MODE_CANCEL, 8'd0, 1'b0, 24'd0, 1'b0);
      send_item(MODE_TICK, 8'd0, 1'b0, 24'd0, 1'b0);
      drain_pipe();
   endtask

   task automatic test_random_traffic();
      cfg_type c;
      int first;
      for (int i = 0; i < 8; i++) begin
         case (i)
            0: c = make_cfg(1'b0, 1'b0, 4'd3, 4'd5, 3'd4);
            1: c = make_cfg(1'b1, 1'b0, 4'd3, 4'd5, 3'd4);
            2: c = make_cfg(1'b1, 1'b1, 4'd5, 4'd8, 3'd5);
            3: c = make_cfg(1'b0, 1'b1, 4'd0, 4'd3, 3'd0);
            4: c = make_cfg(1'b1, 1'b0, 4'd8, 4'd8, 3'd2);
            5: c = make_cfg(1'b1, 1'b1, 4'd0, 4'd3, 3'd5);
            6: c = make_cfg(1'b0, 1'b0, 4'd9, 4'd12, 3'd7);  // exponent above mask limit
            default: c = make_cfg(1'b1, 1'b0, 4'd2, 4'd15, 3'd7);
         endcase
         drain_pipe();
         write_config(c);
         case (i % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 58; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 58; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
         endcase
         first = words_sent;
         while (words_sent - first < PHASE_WORDS)
            run_attempt();
      end
      drain_pipe();
   endtask

   // hold the response side off while requests keep coming
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      write_config(make_cfg(1'b0, 1'b0, 4'd2, 4'd5, 3'd3));
      hold_req = 1'b1;
      for (int i = 0; i < 40; i++)
         send_word(make_word(mode_type'($urandom_range(0, 3))));
      drain_pipe();
   endtask

   initial begin
      reset_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_unslotted();
      test_directed_slotted();
      test_random_traffic();
      test_backpressure();
      drain_pipe();
      if (err_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: files.f
hdl/csma_pkg.sv
hdl/csma_div.sv
hdl/csma_step.sv
hdl/csma_ca_backoff_controller_top.sv
tb/sv/tb_csma_ca_backoff_controller_top.sv
